// ===== rtl/utf8_to_utf16_stream_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8U16_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define U8U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 check failed: next-cycle rule");

`endif

// ===== rtl/utf8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types and constants of the decoder core.
// ----------------------------------------------------------------------------
package utf8u16_pkg;

    localparam int MaxUnits = 3;

    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_OFFSET  = 21'h10000;

    localparam logic [1:0]  CONT_TAG     = 2'b10;

    // Sequence lengths held in the length register.
    localparam logic [2:0]  LEN_NONE = 3'd0;
    localparam logic [2:0]  LEN_TWO  = 3'd2;
    localparam logic [2:0]  LEN_THREE = 3'd3;
    localparam logic [2:0]  LEN_FOUR = 3'd4;
    localparam logic [2:0]  LEN_FIVE = 3'd5;
    localparam logic [2:0]  LEN_SIX  = 3'd6;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_terminator;
    } unit_t;

    // Up to three units made by one byte, valid from index 0 upward.
    typedef struct packed {
        logic [1:0]          count;
        unit_t [MaxUnits-1:0] units;
    } result_set_t;

    typedef struct packed {
        logic seq_open;
    } dec_status_t;

endpackage

// ===== rtl/utf8u16_byte_if.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte channel
// Valid/ready channel that carries one UTF-8 byte and its end mark.
// ----------------------------------------------------------------------------
interface utf8u16_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       string_end;

    modport source (output valid, output byte_in, output string_end, input ready);
    modport sink   (input valid, input byte_in, input string_end, output ready);

endinterface

// ===== rtl/utf8u16_unit_if.sv =====
// ----------------------------------------------------------------------------
// UTF-16 unit channel
// Valid/ready channel that carries one UTF-16 code unit and its terminator flag.
// ----------------------------------------------------------------------------
interface utf8u16_unit_if;

    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_terminator;

    modport source (output valid, output code_unit, output is_terminator, input ready);
    modport sink   (input valid, input code_unit, input is_terminator, output ready);

endinterface

// ===== rtl/utf8u16_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the open sequence and turns each accepted byte into zero to three units.
// ----------------------------------------------------------------------------
module utf8u16_decode (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               byte_in,
    input  logic                     string_end,
    output utf8u16_pkg::result_set_t res,
    output utf8u16_pkg::dec_status_t status
);
    import utf8u16_pkg::*;

    logic [2:0]  seq_len_reg, seq_len_next;
    logic [2:0]  remain_reg, remain_next;
    logic [20:0] accum_reg, accum_next;

    logic [20:0] accum_shift;
    logic [2:0]  remain_dec;
    logic [20:0] supp_w;
    logic        is_cont;

    assign accum_shift = {accum_reg[14:0], byte_in[5:0]};
    assign remain_dec  = (remain_reg != 3'd0) ? remain_reg - 3'd1 : remain_reg;
    assign supp_w      = accum_shift - SUPP_OFFSET;
    assign is_cont     = (byte_in[7:6] == CONT_TAG);

    assign status.seq_open = (seq_len_reg != LEN_NONE);

    always_comb
    begin
        seq_len_next = seq_len_reg;
        remain_next  = remain_reg;
        accum_next   = accum_reg;
        res          = '0;

        if (byte_in == 8'h00)
        begin
            seq_len_next = LEN_NONE;
            remain_next  = 3'd0;
            accum_next   = '0;
            res.units[0] = '{code_unit: 16'h0000, is_terminator: 1'b1};
            res.count    = 2'd1;
        end
        else
        begin
            if ((seq_len_reg != LEN_NONE) && is_cont)
            begin
                accum_next  = accum_shift;
                remain_next = remain_dec;
                if (remain_dec == 3'd0)
                begin
                    case (seq_len_reg)
                        LEN_TWO, LEN_THREE:
                        begin
                            res.units[0] = '{code_unit: accum_shift[15:0], is_terminator: 1'b0};
                            res.count    = 2'd1;
                        end
                        LEN_FOUR:
                        begin
                            if (accum_shift[20:16] != 5'd0)
                            begin
                                // Supplementary value: split into a surrogate pair.
                                res.units[0] = '{code_unit: SURR_HI_BASE | {5'd0, supp_w[20:10]},
                                                 is_terminator: 1'b0};
                                res.units[1] = '{code_unit: SURR_LO_BASE | {6'd0, supp_w[9:0]},
                                                 is_terminator: 1'b0};
                                res.count    = 2'd2;
                            end
                            else
                            begin
                                res.units[0] = '{code_unit: accum_shift[15:0],
                                                 is_terminator: 1'b0};
                                res.count    = 2'd1;
                            end
                        end
                        default:
                        begin
                            // Five and six byte forms complete silently.
                        end
                    endcase
                    seq_len_next = LEN_NONE;
                    remain_next  = 3'd0;
                    accum_next   = '0;
                end
            end
            else
            begin
                // Lead byte: any partial sequence is abandoned.
                seq_len_next = LEN_NONE;
                remain_next  = 3'd0;
                accum_next   = '0;
                if (byte_in[7] == 1'b0)
                begin
                    res.units[0] = '{code_unit: {8'h00, byte_in}, is_terminator: 1'b0};
                    res.count    = 2'd1;
                end
                else if (byte_in < 8'hC0 || byte_in >= 8'hFE)
                begin
                    // Stray continuation or an invalid byte is dropped.
                end
                else if (byte_in < 8'hE0)
                begin
                    seq_len_next = LEN_TWO;
                    remain_next  = 3'd1;
                    accum_next   = {16'd0, byte_in[4:0]};
                end
                else if (byte_in < 8'hF0)
                begin
                    seq_len_next = LEN_THREE;
                    remain_next  = 3'd2;
                    accum_next   = {17'd0, byte_in[3:0]};
                end
                else if (byte_in < 8'hF8)
                begin
                    seq_len_next = LEN_FOUR;
                    remain_next  = 3'd3;
                    accum_next   = {18'd0, byte_in[2:0]};
                end
                else if (byte_in < 8'hFC)
                begin
                    seq_len_next = LEN_FIVE;
                    remain_next  = 3'd4;
                end
                else
                begin
                    seq_len_next = LEN_SIX;
                    remain_next  = 3'd5;
                end
            end

            if (string_end)
            begin
                seq_len_next = LEN_NONE;
                remain_next  = 3'd0;
                accum_next   = '0;
                res.units[res.count] = '{code_unit: 16'h0000, is_terminator: 1'b1};
                res.count            = res.count + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= LEN_NONE;
            remain_reg  <= 3'd0;
            accum_reg   <= '0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            remain_reg  <= remain_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

// ===== rtl/utf8u16_outbuf.sv =====
// ----------------------------------------------------------------------------
// UTF-16 result buffer
// Registers the units of one byte and hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module utf8u16_outbuf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  utf8u16_pkg::result_set_t res,
    output logic                     load_ok,
    utf8u16_unit_if.source           units
);
    import utf8u16_pkg::*;

    unit_t [MaxUnits-1:0] buf_reg, buf_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 pop;

    assign units.valid         = (cnt_reg != 2'd0);
    assign units.code_unit     = buf_reg[0].code_unit;
    assign units.is_terminator = buf_reg[0].is_terminator;
    assign pop                 = units.valid && units.ready;

    // A new set may enter once the buffer is empty or empties this cycle.
    assign load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && units.ready);

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
        if (load)
        begin
            buf_next = res.units;
            cnt_next = res.count;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/utf8_to_utf16_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder core
// Decodes a UTF-8 byte stream into UTF-16 code units with string terminators.
// ----------------------------------------------------------------------------
// Usage:
// Bytes arrive on the utf8 channel, one item per valid/ready handshake, each
// with a string_end mark. Code units leave on the utf16 channel, one item per
// handshake; is_terminator flags the zero unit that closes each string.
// A byte makes zero to three units: nothing for a lead or middle byte, one
// unit for ASCII or a finished 2/3/4-byte sequence, two for a surrogate pair,
// plus a terminator on a zero byte or a marked end byte.
// The units of a byte accepted at a clock edge are registered and are on the
// output from the next cycle on. A byte that yields at most one unit can
// follow every cycle while the receiver is ready; after a byte with more
// units the input waits for the result buffer, which drains one unit per cycle.
// Reset clears the open sequence and empties the result buffer.
// When the receiver stalls, the waiting unit holds and the buffer keeps the
// rest; the input is still taken in the cycle the last buffered unit leaves.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_stream_decoder_core_macros.svh"

module utf8_to_utf16_stream_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    utf8u16_byte_if.sink  utf8,
    utf8u16_unit_if.source utf16
);
    import utf8u16_pkg::*;

    result_set_t res;
    dec_status_t status;
    logic        load_ok;
    logic        accept;

    // The input is ready whenever the result buffer can take a full set.
    assign utf8.ready = load_ok;
    assign accept     = utf8.valid && load_ok;

    // Sequence state and per-byte decode; state advances only on an accepted item.
    utf8u16_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_in    (utf8.byte_in),
        .string_end (utf8.string_end),
        .res        (res),
        .status     (status)
    );

    // Result register: up to three units, presented one per cycle while the receiver is ready.
    utf8u16_outbuf u_outbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .res     (res),
        .load_ok (load_ok),
        .units   (utf16)
    );

    // A terminator unit always carries code zero.
    `U8U16_ASSERT_NOW(a_term_zero, utf16.valid && utf16.is_terminator, utf16.code_unit == 16'h0000)

    // A zero byte puts the terminator first on the output in the next cycle.
    `U8U16_ASSERT_NEXT(a_zero_byte_term, accept && (utf8.byte_in == 8'h00), utf16.valid && utf16.is_terminator)

    // An ASCII byte outside a sequence appears unchanged in the next cycle.
    `U8U16_ASSERT_NEXT(a_ascii_pass, accept && !status.seq_open && (utf8.byte_in[7] == 1'b0) && (utf8.byte_in != 8'h00), utf16.valid && !utf16.is_terminator && (utf16.code_unit == {8'h00, $past(utf8.byte_in)}))

endmodule

// ===== verif/utf8u16_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder scoreboard
// Decodes each accepted byte into the UTF-16 units it should produce and
// compares them, in order, with the units that leave the decoder.
// ----------------------------------------------------------------------------
package utf8u16_tb_pkg;

    import utf8u16_pkg::*;

    class utf16_unit_ledger;

        logic [2:0]  seq_len;
        logic [2:0]  remaining;
        logic [20:0] accum;
        unit_t       expected_units[$];
        int          errors;
        int          unit_index;

        function new();
            clear_sequence();
            errors = 0;
            unit_index = 0;
        endfunction

        function void clear_sequence();
            seq_len = LEN_NONE;
            remaining = 3'd0;
            accum = 21'd0;
        endfunction

        function void push_unit(logic [15:0] code, logic term);
            unit_t u;
            u.code_unit = code;
            u.is_terminator = term;
            expected_units.push_back(u);
        endfunction

        // A sequence has its last continuation byte: emit its unit or pair.
        function void finish_sequence();
            logic [20:0] w;
            case (seq_len)
                LEN_TWO, LEN_THREE: push_unit(accum[15:0], 1'b0);
                LEN_FOUR:
                begin
                    if (accum > 21'h00FFFF)
                    begin
                        w = accum - SUPP_OFFSET;
                        push_unit(SURR_HI_BASE | {5'd0, w[20:10]}, 1'b0);
                        push_unit(SURR_LO_BASE | {6'd0, w[9:0]}, 1'b0);
                    end
                    else
                    begin
                        push_unit(accum[15:0], 1'b0);
                    end
                end
                default: ;
            endcase
            clear_sequence();
        endfunction

        function void open_sequence(logic [7:0] b);
            clear_sequence();
            if (b < 8'h80)
            begin
                push_unit({8'd0, b}, 1'b0);
            end
            else if (b < 8'hC0 || b >= 8'hFE)
            begin
                // Stray continuation, 0xFE and 0xFF make nothing.
            end
            else if (b < 8'hE0)
            begin
                seq_len = LEN_TWO;
                remaining = 3'd1;
                accum = {16'd0, b[4:0]};
            end
            else if (b < 8'hF0)
            begin
                seq_len = LEN_THREE;
                remaining = 3'd2;
                accum = {17'd0, b[3:0]};
            end
            else if (b < 8'hF8)
            begin
                seq_len = LEN_FOUR;
                remaining = 3'd3;
                accum = {18'd0, b[2:0]};
            end
            else if (b < 8'hFC)
            begin
                seq_len = LEN_FIVE;
                remaining = 3'd4;
            end
            else
            begin
                seq_len = LEN_SIX;
                remaining = 3'd5;
            end
        endfunction

        // Notes one accepted byte and queues the units it must produce.
        function void take_byte(logic [7:0] b, logic last);
            if (b == 8'h00)
            begin
                clear_sequence();
                push_unit(16'h0000, 1'b1);
                return;
            end
            if (seq_len != LEN_NONE && b[7:6] == CONT_TAG)
            begin
                accum = {accum[14:0], b[5:0]};
                if (remaining != 3'd0)
                    remaining = remaining - 3'd1;
                if (remaining == 3'd0)
                    finish_sequence();
            end
            else
            begin
                open_sequence(b);
            end
            if (last)
            begin
                clear_sequence();
                push_unit(16'h0000, 1'b1);
            end
        endfunction

        function int pending();
            return expected_units.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Compares one unit that left the decoder with the oldest expected one.
        task check_unit(logic [15:0] code, logic term);
            unit_t want;
            unit_index++;
            if (expected_units.size() == 0)
            begin
                report($sformatf("unit %0d 0x%04h term %0b arrived with none expected",
                                 unit_index, code, term));
                return;
            end
            want = expected_units.pop_front();
            if (code !== want.code_unit)
                report($sformatf("unit %0d code_unit 0x%04h, expected 0x%04h",
                                 unit_index, code, want.code_unit));
            if (term !== want.is_terminator)
                report($sformatf("unit %0d is_terminator %0b, expected %0b",
                                 unit_index, term, want.is_terminator));
        endtask

    endclass

endpackage

// ===== verif/utf8_to_utf16_stream_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder testbench
// Feeds directed and then random UTF-8 byte streams through the decoder with
// random idle cycles on both channels and checks every UTF-16 unit against an
// independent decoder kept in the scoreboard.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_core_tb;

    import utf8u16_tb_pkg::utf16_unit_ledger;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } byte_item_t;

    // Number of random items after the directed part.
    localparam int RandomItems    = 100;
    // Cycles without any item moving before the run is declared hung.
    localparam int IdleLimit      = 2000;
    // The one long receiver stall, and how many units pass before it starts.
    localparam int HoldCycles     = 80;
    localparam int HoldAfterUnits = 30;
    // Quiet cycles after the last expected unit, to catch any extra unit.
    localparam int DrainCycles    = 10;

    logic clk;
    logic rst_n;

    utf8u16_byte_if utf8 ();
    utf8u16_unit_if utf16 ();

    utf8_to_utf16_stream_decoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8),
        .utf16 (utf16)
    );

    utf16_unit_ledger ledger;
    byte_item_t       byte_plan[$];
    int               units_seen = 0;
    int               idle_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The watchdog restarts its count whenever an item moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((utf8.valid && utf8.ready) || (utf16.valid && utf16.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task plan_byte(input logic [7:0] value, input logic last);
        byte_item_t item;
        item.value = value;
        item.last = last;
        byte_plan.push_back(item);
    endtask

    // Appends a lead byte for a sequence of the given length followed by the
    // given number of continuation bytes, all with random payload bits. A
    // length of one is a plain ASCII byte.
    task plan_sequence(input int len, input int conts);
        logic [7:0] lead;
        case (len)
            1: lead = 8'($urandom_range(1, 127));
            2: lead = 8'hC0 | 8'($urandom_range(0, 31));
            3: lead = 8'hE0 | 8'($urandom_range(0, 15));
            4: lead = 8'hF0 | 8'($urandom_range(0, 7));
            5: lead = 8'hF8 | 8'($urandom_range(0, 3));
            default: lead = 8'hFC | 8'($urandom_range(0, 1));
        endcase
        plan_byte(lead, 1'b0);
        repeat (conts)
            plan_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
    endtask

    // Directed part: field extremes and each corner of the decoding rules.
    task plan_directed();
        // An ASCII byte marked as the end gives the unit and then the terminator.
        plan_byte(8'h7F, 1'b1);
        // A four-byte form above 0xFFFF becomes a surrogate pair.
        plan_byte(8'hF0, 1'b0);
        plan_byte(8'h9F, 1'b0);
        plan_byte(8'h98, 1'b0);
        plan_byte(8'h80, 1'b0);
        // The largest four-byte value, far beyond the Unicode range, still
        // forms a pair by OR-ing into the surrogate bases.
        plan_byte(8'hF7, 1'b0);
        plan_byte(8'hBF, 1'b0);
        plan_byte(8'hBF, 1'b0);
        plan_byte(8'hBF, 1'b0);
        // An overlong two-byte zero is passed on as an ordinary unit.
        plan_byte(8'hC0, 1'b0);
        plan_byte(8'h80, 1'b0);
        // A stray continuation byte and the two invalid bytes are dropped.
        plan_byte(8'h80, 1'b0);
        plan_byte(8'hFE, 1'b0);
        plan_byte(8'hFF, 1'b0);
        // A broken three-byte sequence: the ASCII byte restarts decoding.
        plan_byte(8'hE2, 1'b0);
        plan_byte(8'h82, 1'b0);
        plan_byte(8'h41, 1'b0);
        // A complete six-byte form produces nothing.
        plan_byte(8'hFD, 1'b0);
        repeat (5)
            plan_byte(8'hBF, 1'b0);
        // A zero byte inside a sequence drops it and ends the string.
        plan_byte(8'hC3, 1'b0);
        plan_byte(8'h00, 1'b0);
        // The marked end byte completes a sequence before the terminator.
        plan_byte(8'hC3, 1'b0);
        plan_byte(8'hA9, 1'b1);
        // The marked end on a lead byte drops the sequence it opens.
        plan_byte(8'hE1, 1'b1);
    endtask

    // Random part: mostly well-formed sequences with random payload, the rest
    // broken sequences, raw noise and string ends.
    task plan_random();
        int goal;
        int kind;
        int len;
        goal = byte_plan.size() + RandomItems;
        while (byte_plan.size() < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                plan_sequence(1, 0);
            end
            else if (kind < 45)
            begin
                plan_sequence(2, 1);
            end
            else if (kind < 60)
            begin
                plan_sequence(3, 2);
            end
            else if (kind < 75)
            begin
                plan_sequence(4, 3);
            end
            else if (kind < 79)
            begin
                plan_sequence(5, 4);
            end
            else if (kind < 82)
            begin
                plan_sequence(6, 5);
            end
            else if (kind < 90)
            begin
                // Cut short; whatever follows interrupts it.
                len = $urandom_range(2, 6);
                plan_sequence(len, $urandom_range(0, len - 2));
            end
            else if (kind < 95)
            begin
                plan_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                plan_byte(8'h00, 1'($urandom_range(0, 1)));
            end
            // Now and then the string ends on the last byte just planned.
            if (kind < 95 && $urandom_range(0, 99) < 7)
                byte_plan[byte_plan.size() - 1].last = 1'b1;
        end
    endtask

    // Offers the planned bytes one item at a time. Each item waits a random
    // number of idle cycles first, except in bursts where it follows at once.
    task drive_bytes();
        int gap;
        bit burst;
        burst = 1'b0;
        foreach (byte_plan[i])
        begin
            if ($urandom_range(0, 11) == 0)
                burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 10);
            if (gap != 0)
            begin
                utf8.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            utf8.valid <= 1'b1;
            utf8.byte_in <= byte_plan[i].value;
            utf8.string_end <= byte_plan[i].last;
            do
                @(posedge clk);
            while (!utf8.ready);
            ledger.take_byte(byte_plan[i].value, byte_plan[i].last);
        end
        utf8.valid <= 1'b0;
    endtask

    // Takes units from the decoder with random stalls. Once, after a few dozen
    // units, it holds ready low for a long stretch while bytes keep coming,
    // so the result buffer fills and the decoder has to stall its input.
    task take_units();
        int gap;
        bit burst;
        bit held;
        burst = 1'b0;
        held = 1'b0;
        forever
        begin
            if (!held && units_seen >= HoldAfterUnits)
            begin
                held = 1'b1;
                gap = HoldCycles;
            end
            else
            begin
                if ($urandom_range(0, 11) == 0)
                    burst = !burst;
                gap = burst ? 0 : $urandom_range(0, 10);
            end
            if (gap != 0)
            begin
                utf16.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            utf16.ready <= 1'b1;
            do
                @(posedge clk);
            while (!utf16.valid);
            units_seen++;
            ledger.check_unit(utf16.code_unit, utf16.is_terminator);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        utf8.valid <= 1'b0;
        utf8.byte_in <= 8'h00;
        utf8.string_end <= 1'b0;
        utf16.ready <= 1'b0;
        ledger = new();
        plan_directed();
        plan_random();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        fork
            take_units();
        join_none
        drive_bytes();

        // Every byte is in; wait for the units still owed, then stay a little
        // longer so that a spurious extra unit gets caught.
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (ledger.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
